### design/ddc_pkg.sv
package ddc_pkg;

    // filter and oscillator geometry
    localparam int TAPS      = 31;
    localparam int LO_BITS   = 10;
    localparam int HALF      = TAPS / 2;
    localparam int LAG       = TAPS - 1 - HALF;
    localparam int TAP_W     = $clog2(TAPS);
    localparam int FRAC_BITS = LO_BITS - 2;
    localparam int FRAC_N    = 1 << FRAC_BITS;

    // field and datapath widths
    localparam int SMP_W   = 16;
    localparam int COEF_W  = 18;
    localparam int IDX_W   = 7;
    localparam int FILL_W  = 7;
    localparam int OSC_W   = 17;
    localparam int MIX_W   = 34;
    localparam int PROD_W  = COEF_W + SMP_W;
    localparam int ACC_W   = PROD_W + 7;
    localparam int PHASE_W = 32;

    localparam logic [FILL_W-1:0] FILL_MAX = '1;
    localparam logic [FILL_W-1:0] LAG_F    = FILL_W'(LAG);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 1'd1;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYP,
        S_OSC,
        S_MUL,
        S_PUSH,
        S_NEXT,
        S_ZERO,
        S_MAC,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic mv;
        logic clr;
    } t_cell_ctl;

    typedef struct packed {
        logic osc_en;
        logic mul_en;
    } t_mix_ctl;

    typedef struct packed {
        logic             run;
        logic             fin;
        logic [TAP_W-1:0] k;
    } t_mac_ctl;

    typedef struct packed {
        logic                     wr;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] val;
    } t_coef_wr;

    // q30 coefficients of the quarter-wave sine polynomial
    localparam logic [63:0] POLY [7] = '{
        64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };

    // sin(pi*u/2) in q15, u in q30
    function automatic logic [14:0] quarter_sine(logic [63:0] u);
        logic [63:0] v;
        logic [63:0] s;
        v = (u * u) >> 30;
        s = POLY[6];
        for (int i = 5; i >= 0; i--) begin
            s = POLY[i] - ((s * v) >> 30);
        end
        s = (s * u) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

    typedef logic [14:0] t_sine_tab [FRAC_N];

    function automatic t_sine_tab build_tab(logic cos_sel);
        t_sine_tab   tab;
        logic [63:0] u;
        for (int f = 0; f < FRAC_N; f++) begin
            u = 64'(f) << (32 - LO_BITS);
            if (cos_sel) begin
                u = (64'd1 << 30) - u;
            end
            tab[f] = quarter_sine(u);
        end
        return tab;
    endfunction

    localparam t_sine_tab SIN_TAB = build_tab(1'b0);
    localparam t_sine_tab COS_TAB = build_tab(1'b1);

    // mixer product q4.30 to q1.15, round half up, saturate
    function automatic logic signed [SMP_W-1:0] rnd_sat_mix(logic signed [MIX_W-1:0] p);
        logic signed [MIX_W-1:0] w;
        w = (p + MIX_W'(16384)) >>> 15;
        if (w > MIX_W'(32767)) begin
            return 16'sh7fff;
        end else if (w < -MIX_W'(32768)) begin
            return 16'sh8000;
        end
        return w[SMP_W-1:0];
    endfunction

    // filter sum q9.32 to q1.15, round half up, saturate
    function automatic logic signed [SMP_W-1:0] rnd_sat_acc(logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] w;
        w = (a + ACC_W'(65536)) >>> 17;
        if (w > ACC_W'(32767)) begin
            return 16'sh7fff;
        end else if (w < -ACC_W'(32768)) begin
            return 16'sh8000;
        end
        return w[SMP_W-1:0];
    endfunction

endpackage

### design/ddc_cell.sv
module ddc_cell import ddc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic signed [SMP_W-1:0] i_prev_i,
    input  logic signed [SMP_W-1:0] i_prev_q,
    output logic signed [SMP_W-1:0] o_i,
    output logic signed [SMP_W-1:0] o_q
);

    logic signed [SMP_W-1:0] r_i;
    logic signed [SMP_W-1:0] r_q;

    // one i/q line entry, takes its neighbor's value on a move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_i <= '0;
            r_q <= '0;
        end else if (i_ctl.mv) begin
            r_i <= i_prev_i;
            r_q <= i_prev_q;
        end
    end

    assign o_i = r_i;
    assign o_q = r_q;

endmodule

### design/ddc_mixer.sv
module ddc_mixer import ddc_pkg::*; (
    input  logic                    i_clk,
    input  t_mix_ctl                i_ctl,
    input  logic [PHASE_W-1:0]      i_phase,
    input  logic signed [SMP_W-1:0] i_sample,
    output logic signed [SMP_W-1:0] o_mix_i,
    output logic signed [SMP_W-1:0] o_mix_q
);

    logic [LO_BITS-1:0]         angle;
    logic [1:0]                 quad;
    logic [FRAC_BITS-1:0]       frac;
    logic signed [OSC_W-1:0]    sin_a;
    logic signed [OSC_W-1:0]    sin_b;
    logic signed [OSC_W-1:0]    cos_v;
    logic signed [OSC_W-1:0]    sin_v;
    logic signed [OSC_W-1:0]    r_cos;
    logic signed [OSC_W-1:0]    r_sin;
    logic signed [MIX_W-1:0]    prod_i;
    logic signed [MIX_W-1:0]    prod_s;
    logic signed [MIX_W-1:0]    r_prod_i;
    logic signed [MIX_W-1:0]    r_prod_q;

    // quarter-wave lookup and quadrant folding
    always_comb begin
        angle = i_phase[PHASE_W-1 -: LO_BITS];
        quad  = angle[LO_BITS-1 -: 2];
        frac  = angle[FRAC_BITS-1:0];
        sin_a = OSC_W'(SIN_TAB[frac]);
        sin_b = OSC_W'(COS_TAB[frac]);
        case (quad)
            2'd0: begin
                sin_v = sin_a;
                cos_v = sin_b;
            end
            2'd1: begin
                sin_v = sin_b;
                cos_v = -sin_a;
            end
            2'd2: begin
                sin_v = -sin_a;
                cos_v = -sin_b;
            end
            default: begin
                sin_v = -sin_b;
                cos_v = sin_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.osc_en) begin
            r_cos <= cos_v;
            r_sin <= sin_v;
        end
    end

    // mixer products
    assign prod_i = MIX_W'(i_sample) * MIX_W'(r_cos);
    assign prod_s = MIX_W'(i_sample) * MIX_W'(r_sin);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod_i <= prod_i;
            r_prod_q <= -prod_s;
        end
    end

    assign o_mix_i = rnd_sat_mix(r_prod_i);
    assign o_mix_q = rnd_sat_mix(r_prod_q);

endmodule

### design/ddc_mac.sv
module ddc_mac import ddc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_coef_wr                i_wr,
    input  t_mac_ctl                i_ctl,
    input  logic signed [SMP_W-1:0] i_tail_i,
    input  logic signed [SMP_W-1:0] i_tail_q,
    output logic signed [SMP_W-1:0] o_res_i,
    output logic signed [SMP_W-1:0] o_res_q
);

    logic signed [COEF_W-1:0] r_coef [TAPS];
    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_q;
    logic signed [ACC_W-1:0]  r_acc_i;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic signed [COEF_W-1:0] coef_k;
    logic                     wr_ok;
    logic                     first;

    assign wr_ok  = i_wr.wr && (i_wr.idx < IDX_W'(TAPS));
    assign coef_k = r_coef[i_ctl.k];
    assign first  = (i_ctl.k == '0);

    // coefficient store, out-of-range indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (wr_ok) begin
            r_coef[i_wr.idx[TAP_W-1:0]] <= i_wr.val;
        end
    end

    // multiply one tap per cycle, accumulate the previous product
    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            r_prod_i <= PROD_W'(coef_k) * PROD_W'(i_tail_i);
            r_prod_q <= PROD_W'(coef_k) * PROD_W'(i_tail_q);
            if (first) begin
                r_acc_i <= '0;
                r_acc_q <= '0;
            end else begin
                r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
                r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
            end
        end else if (i_ctl.fin) begin
            r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
        end
    end

    assign o_res_i = rnd_sat_acc(r_acc_i);
    assign o_res_q = rnd_sat_acc(r_acc_q);

endmodule

### design/ddc_mixer_complex_fir.sv
// digital down converter: oscillator, complex mixer and centred complex fir
// input stream: tuser selects a sample (0) or a coefficient load (1); tlast
// marks the last sample of a frame. a coefficient load is written as it is
// accepted and gives no result. a sample is mixed to i/q and shifted into
// a ring of line cells; each result rotates the ring once through a single
// i/q multiply-accumulate unit. a sample keeps the input stalled until the
// sequencer is back in idle after its last result; its first result passes
// through the oscillator, mixer, push, next, multiply-accumulate, finish and
// emit states. the frame's last sample flushes up to LAG results, shifting
// zeros into the ring before each; for a frame of fewer than LAG+1 samples
// the first flush result is preceded by zeros that pad the frame to LAG+1
// samples. bypass samples load their result, i = sample, q = 0, in S_BYP.
// output: tdata {out_q, out_i}, tlast frame_done, tuser run_last.
// a one-entry output register holds the result; a stalled receiver holds the
// sequencer at its next result and no new request is taken meanwhile.
// config writes (phase increment, bypass mode) are always ready; the user
// must make them only while the block is idle, the block does not enforce it.
// reset clears the filter lines, coefficients, phase, frame count and
// config registers; no clearing pass is needed.
module ddc_mixer_complex_fir import ddc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [47:0]          i_s_tdata,   // sample, coef_index, coef_value
    input  logic                 i_s_tlast,
    input  logic [0:0]           i_s_tuser,   // req_type
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_m_tdata,   // out_i, out_q
    output logic                 o_m_tlast,
    output logic [0:0]           o_m_tuser,   // run_last
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_state                  r_state;
    t_state                  n_state;
    logic signed [SMP_W-1:0] r_x;
    logic                    r_end;
    logic [PHASE_W-1:0]      r_phase;
    logic [PHASE_W-1:0]      r_step;
    logic                    r_bypass;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_main;
    logic [FILL_W-1:0]       r_flush_left;
    logic [FILL_W-1:0]       r_skip;
    logic [TAP_W-1:0]        r_k;
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_i;
    logic signed [SMP_W-1:0] r_out_q;
    logic                    r_out_done;
    logic                    r_out_last;

    logic                    s_acc;
    logic                    slot_free;
    logic                    out_load;
    logic                    line_clr;
    logic [FILL_W-1:0]       fill_new;
    logic                    fill_over;
    t_cell_ctl               cell_ctl;
    t_mix_ctl                mix_ctl;
    t_mac_ctl                mac_ctl;
    t_coef_wr                coef_wr;
    logic signed [SMP_W-1:0] head_i;
    logic signed [SMP_W-1:0] head_q;
    logic signed [SMP_W-1:0] mix_i;
    logic signed [SMP_W-1:0] mix_q;
    logic signed [SMP_W-1:0] res_i;
    logic signed [SMP_W-1:0] res_q;
    logic signed [SMP_W-1:0] w_i [TAPS];
    logic signed [SMP_W-1:0] w_q [TAPS];

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign slot_free = !r_out_valid || i_m_tready;
    assign fill_new  = (r_fill == FILL_MAX) ? r_fill : r_fill + 1'b1;
    assign fill_over = fill_new > LAG_F;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tuser[0] == REQ_SAMPLE) begin
                    n_state = r_bypass ? S_BYP : S_OSC;
                end
            end
            S_BYP: begin
                if (slot_free) n_state = S_IDLE;
            end
            S_OSC:  n_state = S_MUL;
            S_MUL:  n_state = S_PUSH;
            S_PUSH: n_state = S_NEXT;
            S_NEXT: begin
                if (r_main) n_state = S_MAC;
                else if (r_flush_left != '0) n_state = S_ZERO;
                else n_state = S_IDLE;
            end
            S_ZERO: begin
                if (r_skip == FILL_W'(1)) n_state = S_MAC;
            end
            S_MAC: begin
                if (r_k == TAP_W'(TAPS - 1)) n_state = S_FIN;
            end
            S_FIN: n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) n_state = S_NEXT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready   = (r_state == S_IDLE);
        out_load     = ((r_state == S_BYP) || (r_state == S_EMIT)) && slot_free;
        line_clr     = (r_state == S_NEXT) && !r_main && (r_flush_left == '0) && r_end;
        cell_ctl.mv  = (r_state == S_PUSH) || (r_state == S_ZERO) || (r_state == S_MAC);
        cell_ctl.clr = line_clr;
        mix_ctl.osc_en = (r_state == S_OSC);
        mix_ctl.mul_en = (r_state == S_MUL);
        mac_ctl.run  = (r_state == S_MAC);
        mac_ctl.fin  = (r_state == S_FIN);
        mac_ctl.k    = r_k;
        coef_wr.wr   = s_acc && (i_s_tuser[0] == REQ_COEF);
        coef_wr.idx  = i_s_tdata[22:16];
        coef_wr.val  = i_s_tdata[40:23];
        case (r_state)
            S_PUSH: begin
                head_i = mix_i;
                head_q = mix_q;
            end
            S_MAC: begin
                head_i = w_i[TAPS-1];
                head_q = w_q[TAPS-1];
            end
            default: begin
                head_i = '0;
                head_q = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= '0;
            r_step       <= '0;
            r_bypass     <= 1'b0;
            r_fill       <= '0;
            r_main       <= 1'b0;
            r_flush_left <= '0;
            r_skip       <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PHASE_INC) r_step <= i_cfg_data;
                if (i_cfg_index == CFG_BYPASS) r_bypass <= i_cfg_data[0];
            end
            if (r_state == S_PUSH) begin
                r_main <= fill_over;
                if (r_end) begin
                    r_flush_left <= fill_over ? LAG_F : fill_new;
                    r_skip       <= fill_over ? FILL_W'(1) : LAG_F + 1'b1 - fill_new;
                    r_fill       <= '0;
                    r_phase      <= '0;
                end else begin
                    r_flush_left <= '0;
                    r_fill       <= fill_new;
                    r_phase      <= r_phase + r_step;
                end
            end
            if (r_state == S_ZERO && r_skip != FILL_W'(1)) begin
                r_skip <= r_skip - 1'b1;
            end
            if (r_state == S_MAC) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == S_FIN) begin
                r_k <= '0;
            end
            if (r_state == S_EMIT && slot_free) begin
                if (r_main) begin
                    r_main <= 1'b0;
                end else begin
                    r_flush_left <= r_flush_left - 1'b1;
                    r_skip       <= FILL_W'(1);
                end
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_x   <= i_s_tdata[15:0];
            r_end <= i_s_tlast;
        end
        if (out_load) begin
            if (r_state == S_BYP) begin
                r_out_i    <= r_x;
                r_out_q    <= '0;
                r_out_done <= r_end;
                r_out_last <= 1'b1;
            end else begin
                r_out_i    <= res_i;
                r_out_q    <= res_q;
                r_out_done <= !r_main && (r_flush_left == FILL_W'(1));
                r_out_last <= r_main ? !r_end : (r_flush_left == FILL_W'(1));
            end
        end
    end

    ddc_mixer u_mixer (
        .i_clk    (i_clk),
        .i_ctl    (mix_ctl),
        .i_phase  (r_phase),
        .i_sample (r_x),
        .o_mix_i  (mix_i),
        .o_mix_q  (mix_q)
    );

    // ring of line cells, newest at cell 0
    for (genvar j = 0; j < TAPS; j++) begin : g_line
        if (j == 0) begin : g_head
            ddc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (cell_ctl),
                .i_prev_i (head_i),
                .i_prev_q (head_q),
                .o_i      (w_i[j]),
                .o_q      (w_q[j])
            );
        end else begin : g_body
            ddc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (cell_ctl),
                .i_prev_i (w_i[j-1]),
                .i_prev_q (w_q[j-1]),
                .o_i      (w_i[j]),
                .o_q      (w_q[j])
            );
        end
    end

    ddc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (coef_wr),
        .i_ctl    (mac_ctl),
        .i_tail_i (w_i[TAPS-1]),
        .i_tail_q (w_q[TAPS-1]),
        .o_res_i  (res_i),
        .o_res_q  (res_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_q, r_out_i};
    assign o_m_tlast   = r_out_done;
    assign o_m_tuser   = r_out_last;

    // frame end result always closes the request's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0])
        else $error("frame_done without run_last");

    // tap counter stays within the filter length
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MAC |-> r_k <= TAP_W'(TAPS - 1))
        else $error("tap counter out of range");

    // pending flush never exceeds the lookahead
    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_left <= LAG_F)
        else $error("flush count beyond lookahead");

    // the last flush result leaves nothing pending
    a_flush_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && slot_free && !r_main && r_flush_left == FILL_W'(1)
        |=> r_state == S_NEXT && r_flush_left == '0)
        else $error("flush did not close the frame");

endmodule
